// ===== design/iphc_pkg.sv =====
// Shared types and constants for the IPHC header compressor.
package iphc_pkg;

  localparam logic [63:0] LL_PREFIX    = 64'hFE80_0000_0000_0000;
  localparam logic [63:0] MCAST_LL_ALL = 64'hFF02_0000_0000_0000;
  localparam logic [7:0]  MCAST_TOP    = 8'hFF;
  localparam logic [2:0]  IPHC_DISPATCH = 3'b011;
  localparam logic [7:0]  HOP_ONE      = 8'd1;
  localparam logic [7:0]  HOP_64       = 8'd64;
  localparam logic [7:0]  HOP_255      = 8'd255;

  // One IPv6 header to compress.
  typedef struct packed {
    logic [7:0]  traffic_class;
    logic [19:0] flow_label;
    logic [7:0]  next_header;
    logic        nh_compressed;
    logic [7:0]  hop_limit;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [63:0] link_dst_mac;
  } in_t;

  // One byte of the compressed header stream.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  // Compressed header as segments; data is left-justified, MSB byte first.
  typedef struct packed {
    logic [15:0]  disp;
    logic [31:0]  tf;
    logic [2:0]   tf_len;
    logic [7:0]   nh;
    logic         nh_len;
    logic [7:0]   hl;
    logic         hl_len;
    logic [127:0] src;
    logic [4:0]   src_len;
    logic [127:0] dst;
    logic [4:0]   dst_len;
  } hdr_t;

endpackage

// ===== design/iphc_enc.sv =====
// Combinational IPHC field encoder: one IPv6 header into dispatch bits and inline segments.
module iphc_enc (
  input  iphc_pkg::in_t  item_i,
  input  logic [63:0]    own_mac_i,
  output iphc_pkg::hdr_t hdr_o
);

  logic [1:0] tf_code;
  logic       nh_bit;
  logic [1:0] hlim;
  logic       sac;
  logic [1:0] sam;
  logic       mcast;
  logic [1:0] dam;
  logic       mc_short;

  assign mc_short = (item_i.dst_addr_hi[47:0] == 48'd0);

  always_comb begin
    hdr_o    = '0;
    tf_code  = 2'b00;
    nh_bit   = 1'b0;
    hlim     = 2'b00;
    sac      = 1'b0;
    sam      = 2'b00;
    mcast    = 1'b0;
    dam      = 2'b00;

    // traffic class / flow label
    if (item_i.flow_label == 20'd0) begin
      if (item_i.traffic_class == 8'd0) begin
        tf_code = 2'b11;
      end else begin
        tf_code      = 2'b10;
        hdr_o.tf     = {item_i.traffic_class, 24'd0};
        hdr_o.tf_len = 3'd1;
      end
    end else if (item_i.traffic_class[5:0] == 6'd0) begin
      tf_code      = 2'b01;
      hdr_o.tf     = {item_i.traffic_class[7:6], 2'b00, item_i.flow_label, 8'd0};
      hdr_o.tf_len = 3'd3;
    end else begin
      tf_code      = 2'b00;
      hdr_o.tf     = {item_i.traffic_class, 4'd0, item_i.flow_label};
      hdr_o.tf_len = 3'd4;
    end

    // next header
    if (item_i.nh_compressed) begin
      nh_bit = 1'b1;
    end else begin
      hdr_o.nh     = item_i.next_header;
      hdr_o.nh_len = 1'b1;
    end

    // hop limit
    priority if (item_i.hop_limit == iphc_pkg::HOP_ONE) begin
      hlim = 2'b01;
    end else if (item_i.hop_limit == iphc_pkg::HOP_64) begin
      hlim = 2'b10;
    end else if (item_i.hop_limit == iphc_pkg::HOP_255) begin
      hlim = 2'b11;
    end else begin
      hdr_o.hl     = item_i.hop_limit;
      hdr_o.hl_len = 1'b1;
    end

    // source
    priority if (item_i.src_addr_hi == iphc_pkg::LL_PREFIX) begin
      if (item_i.src_addr_lo == own_mac_i) begin
        sam = 2'b11;
      end else begin
        sam           = 2'b01;
        hdr_o.src     = {item_i.src_addr_lo, 64'd0};
        hdr_o.src_len = 5'd8;
      end
    end else if (item_i.src_addr_hi == 64'd0 && item_i.src_addr_lo == 64'd0) begin
      sac = 1'b1;
    end else begin
      hdr_o.src     = {item_i.src_addr_hi, item_i.src_addr_lo};
      hdr_o.src_len = 5'd16;
    end

    // destination
    priority if (item_i.dst_addr_hi == iphc_pkg::LL_PREFIX) begin
      if (item_i.dst_addr_lo == item_i.link_dst_mac) begin
        dam = 2'b11;
      end else begin
        dam           = 2'b01;
        hdr_o.dst     = {item_i.dst_addr_lo, 64'd0};
        hdr_o.dst_len = 5'd8;
      end
    end else if (item_i.dst_addr_hi[63:56] == iphc_pkg::MCAST_TOP) begin
      mcast = 1'b1;
      priority if (item_i.dst_addr_hi == iphc_pkg::MCAST_LL_ALL &&
                   item_i.dst_addr_lo[63:8] == 56'd0) begin
        dam           = 2'b11;
        hdr_o.dst     = {item_i.dst_addr_lo[7:0], 120'd0};
        hdr_o.dst_len = 5'd1;
      end else if (mc_short && item_i.dst_addr_lo[63:24] == 40'd0) begin
        dam           = 2'b10;
        hdr_o.dst     = {item_i.dst_addr_hi[55:48], item_i.dst_addr_lo[23:0], 96'd0};
        hdr_o.dst_len = 5'd4;
      end else if (mc_short && item_i.dst_addr_lo[63:40] == 24'd0) begin
        dam           = 2'b01;
        hdr_o.dst     = {item_i.dst_addr_hi[55:48], item_i.dst_addr_lo[39:0], 80'd0};
        hdr_o.dst_len = 5'd6;
      end else begin
        hdr_o.dst     = {item_i.dst_addr_hi, item_i.dst_addr_lo};
        hdr_o.dst_len = 5'd16;
      end
    end else begin
      hdr_o.dst     = {item_i.dst_addr_hi, item_i.dst_addr_lo};
      hdr_o.dst_len = 5'd16;
    end

    // CID and DAC are always zero (stateless)
    hdr_o.disp = {iphc_pkg::IPHC_DISPATCH, tf_code, nh_bit, hlim,
                  1'b0, sac, sam, mcast, 1'b0, dam};
  end

endmodule

// ===== design/iphc_ser.sv =====
// Header buffer and byte serializer: walks the segments, one byte per cycle.
module iphc_ser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  iphc_pkg::hdr_t hdr_i,
  output logic           free_o,
  output logic           valid_o,
  output iphc_pkg::out_t out_o
);

  typedef enum logic [2:0] {
    SEG_DISP,
    SEG_TF,
    SEG_NH,
    SEG_HL,
    SEG_SRC,
    SEG_DST
  } seg_e;

  localparam int NSEG = 6;

  iphc_pkg::hdr_t hdr_q;
  seg_e           seg_q;
  logic [3:0]     cnt_q;
  logic           active_q;

  logic [NSEG-1:0] nz;
  logic [4:0]      cur_len;
  logic            at_end;
  logic            found;
  seg_e            nxt_seg;
  logic            last_byte;
  logic [7:0]      byte_sel;

  // segments that carry bytes
  assign nz = {hdr_q.dst_len != 5'd0, hdr_q.src_len != 5'd0, hdr_q.hl_len,
               hdr_q.nh_len, hdr_q.tf_len != 3'd0, 1'b1};

  always_comb begin
    unique case (seg_q)
      SEG_DISP: cur_len = 5'd2;
      SEG_TF:   cur_len = {2'b00, hdr_q.tf_len};
      SEG_NH:   cur_len = {4'd0, hdr_q.nh_len};
      SEG_HL:   cur_len = {4'd0, hdr_q.hl_len};
      SEG_SRC:  cur_len = hdr_q.src_len;
      SEG_DST:  cur_len = hdr_q.dst_len;
      default:  cur_len = 5'd0;
    endcase
  end

  always_comb begin
    unique case (seg_q)
      SEG_DISP: byte_sel = cnt_q[0] ? hdr_q.disp[7:0] : hdr_q.disp[15:8];
      SEG_TF:   byte_sel = hdr_q.tf[5'd31 - {cnt_q[1:0], 3'b000} -: 8];
      SEG_NH:   byte_sel = hdr_q.nh;
      SEG_HL:   byte_sel = hdr_q.hl;
      SEG_SRC:  byte_sel = hdr_q.src[7'd127 - {cnt_q, 3'b000} -: 8];
      SEG_DST:  byte_sel = hdr_q.dst[7'd127 - {cnt_q, 3'b000} -: 8];
      default:  byte_sel = 8'd0;
    endcase
  end

  // nearest later segment with bytes
  always_comb begin
    found   = 1'b0;
    nxt_seg = seg_q;
    for (int s = NSEG - 1; s >= 0; s--) begin
      if (3'(s) > seg_q && nz[s]) begin
        found   = 1'b1;
        nxt_seg = seg_e'(3'(s));
      end
    end
  end

  assign at_end    = ({1'b0, cnt_q} == cur_len - 5'd1);
  assign last_byte = active_q && at_end && !found;

  assign free_o        = !active_q || last_byte;
  assign valid_o       = active_q;
  assign out_o.out_byte = byte_sel;
  assign out_o.last     = last_byte;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      hdr_q <= hdr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q    <= SEG_DISP;
      cnt_q    <= 4'd0;
      active_q <= 1'b0;
    end else if (load_i) begin
      seg_q    <= SEG_DISP;
      cnt_q    <= 4'd0;
      active_q <= 1'b1;
    end else if (active_q) begin
      if (at_end) begin
        cnt_q <= 4'd0;
        if (found) begin
          seg_q <= nxt_seg;
        end else begin
          active_q <= 1'b0;
        end
      end else begin
        cnt_q <= cnt_q + 4'd1;
      end
    end
  end

endmodule

// ===== design/ipv6_header_compressor.sv =====
// Top level of the stateless 6LoWPAN IPHC header compressor.
// Usage: a header transaction is taken when start_i is high and busy_o low. It is
// compressed into 2 to 40 bytes that appear on out_o, one byte per cycle while
// valid_o is high, the final byte flagged by out_o.last. The receiver cannot stall:
// every byte must be taken in the cycle it is shown. An accepted header passes the input
// register, then the encoder into the header buffer, before its first byte appears; it
// waits in the input register while the serializer is still busy. The byte serializer
// streams a header's bytes back to back, with no gap between consecutive headers when
// the next one already waits in the input register. One header can wait there while
// the previous one streams out; busy_o is high only then.
// own_mac is written through cfg_we_i/cfg_wdata_i and resets to zero; write it only
// while the block is idle, as the block itself does not enforce this.
module ipv6_header_compressor (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  iphc_pkg::in_t  in_i,
  input  logic           cfg_we_i,
  input  logic [63:0]    cfg_wdata_i,
  output logic           valid_o,
  output iphc_pkg::out_t out_o
);

  iphc_pkg::in_t  item_q;
  logic           item_vld_q;
  logic [63:0]    own_mac_q;
  iphc_pkg::hdr_t hdr;
  logic           ser_free;
  logic           load;
  logic           accept;

  // hand the waiting header to the serializer when its buffer frees up
  assign load   = item_vld_q && ser_free;
  assign busy_o = item_vld_q && !ser_free;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      own_mac_q  <= 64'd0;
    end else begin
      if (accept) begin
        item_vld_q <= 1'b1;
      end else if (load) begin
        item_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        own_mac_q <= cfg_wdata_i;
      end
    end
  end

  iphc_enc u_enc (
    .item_i    (item_q),
    .own_mac_i (own_mac_q),
    .hdr_o     (hdr)
  );

  iphc_ser u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .hdr_i   (hdr),
    .free_o  (ser_free),
    .valid_o (valid_o),
    .out_o   (out_o)
  );

  // a header's bytes are contiguous: no gap before its last byte
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !out_o.last |=> valid_o)
    else $error("byte stream broke before last byte");

  // every header starts with the IPHC dispatch pattern
  a_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (!$past(valid_o) || $past(out_o.last))
      |-> out_o.out_byte[7:5] == iphc_pkg::IPHC_DISPATCH)
    else $error("header did not start with dispatch byte");

  // stalling intake only happens while a header is streaming
  a_busy_streaming: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> valid_o && !out_o.last)
    else $error("busy while serializer free");

endmodule
